@@ src/srarq_pkg.sv @@
// package for the selective-repeat arq controller
// holds action, event, command and frame-kind codes and the back-end state type
// no dependencies
package srarq_pkg;

    localparam int ACT_W = 3;
    localparam int KIND_W = 2;
    localparam int CMD_W = 3;
    localparam int DUR_W = 16;

    typedef enum logic [2:0] {
        ACT_NET_READY  = 3'd0,
        ACT_PHYS_READY = 3'd1,
        ACT_FRAME      = 3'd2,
        ACT_DATA_TMO   = 3'd3,
        ACT_ACK_TMO    = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        CMD_SEND       = 3'd0,
        CMD_START_DATA = 3'd1,
        CMD_STOP_DATA  = 3'd2,
        CMD_START_ACK  = 3'd3,
        CMD_STOP_ACK   = 3'd4,
        CMD_STORE      = 3'd5,
        CMD_DELIVER    = 3'd6,
        CMD_ENABLE     = 3'd7
    } command_t;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    // classified event codes passed from front to back
    typedef enum logic [2:0] {
        EV_NET       = 3'd0,
        EV_PHYS      = 3'd1,
        EV_BAD       = 3'd2,
        EV_DATA      = 3'd3,
        EV_NAK       = 3'd4,
        EV_ACKONLY   = 3'd5,
        EV_DATA_TMO  = 3'd6,
        EV_ACK_TMO   = 3'd7
    } event_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND,
        ST_START_DATA,
        ST_STOP_ACK,
        ST_RX_CHECK,
        ST_STORE,
        ST_DELIVER,
        ST_DELIVER_ACK,
        ST_ACK_LOOP,
        ST_ENABLE
    } state_t;

endpackage

@@ src/srarq_front.sv @@
// front end: accepts event words and classifies them into queue entries
// depends on srarq_pkg
module srarq_front #(
    parameter int SEQ_BITS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_action,
    input  logic                in_good,
    input  logic [1:0]          in_kind,
    input  logic [SEQ_BITS-1:0] in_seq,
    input  logic [SEQ_BITS-1:0] in_ack,
    output logic                q_valid,
    input  logic                q_ready,
    output srarq_pkg::event_t   q_event,
    output logic                q_ignore,
    output logic [SEQ_BITS-1:0] q_seq,
    output logic [SEQ_BITS-1:0] q_ack
);

    localparam int DEPTH = 2;

    logic                valid_reg [DEPTH];
    srarq_pkg::event_t   ev_reg    [DEPTH];
    logic                ign_reg   [DEPTH];
    logic [SEQ_BITS-1:0] seq_reg   [DEPTH];
    logic [SEQ_BITS-1:0] ack_reg   [DEPTH];
    logic                wr_ptr_reg, rd_ptr_reg;
    srarq_pkg::event_t   ev_next;
    logic                ign_next;
    logic                push, pop;

    // classify the incoming event
    always_comb begin
        ev_next  = srarq_pkg::EV_NET;
        ign_next = 1'b0;
        unique case (in_action)
            srarq_pkg::ACT_NET_READY:  ev_next = srarq_pkg::EV_NET;
            srarq_pkg::ACT_PHYS_READY: ev_next = srarq_pkg::EV_PHYS;
            srarq_pkg::ACT_FRAME: begin
                if (!in_good)                            ev_next = srarq_pkg::EV_BAD;
                else if (in_kind == srarq_pkg::KIND_DATA) ev_next = srarq_pkg::EV_DATA;
                else if (in_kind == srarq_pkg::KIND_NAK)  ev_next = srarq_pkg::EV_NAK;
                else                                     ev_next = srarq_pkg::EV_ACKONLY;
            end
            srarq_pkg::ACT_DATA_TMO:   ev_next = srarq_pkg::EV_DATA_TMO;
            srarq_pkg::ACT_ACK_TMO:    ev_next = srarq_pkg::EV_ACK_TMO;
            default: begin
                ev_next  = srarq_pkg::EV_PHYS;
                ign_next = 1'b1;
            end
        endcase
    end

    assign in_ready = !valid_reg[wr_ptr_reg];
    assign push     = in_valid && in_ready;
    assign q_valid  = valid_reg[rd_ptr_reg];
    assign pop      = q_valid && q_ready;
    assign q_event  = ev_reg[rd_ptr_reg];
    assign q_ignore = ign_reg[rd_ptr_reg];
    assign q_seq    = seq_reg[rd_ptr_reg];
    assign q_ack    = ack_reg[rd_ptr_reg];

    // two-entry queue payload
    always_ff @(posedge aclk) begin
        if (push) begin
            ev_reg[wr_ptr_reg]  <= ev_next;
            ign_reg[wr_ptr_reg] <= ign_next;
            seq_reg[wr_ptr_reg] <= in_seq;
            ack_reg[wr_ptr_reg] <= in_ack;
        end
    end

    // queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
            valid_reg[1] <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
        end else begin
            if (push) begin
                valid_reg[wr_ptr_reg] <= 1'b1;
                wr_ptr_reg            <= !wr_ptr_reg;
            end
            if (pop) begin
                valid_reg[rd_ptr_reg] <= 1'b0;
                rd_ptr_reg            <= !rd_ptr_reg;
            end
        end
    end

`ifndef ASSERT_OFF
    // a push only lands on an empty entry, and each push or pop moves its pointer
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !valid_reg[wr_ptr_reg])
        else $error("queue overflow");
    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> rd_ptr_reg != $past(rd_ptr_reg))
        else $error("read pointer stuck");
    a_push_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> wr_ptr_reg != $past(wr_ptr_reg))
        else $error("write pointer stuck");
`endif

endmodule

@@ src/srarq_back.sv @@
// back end: window state and command sequencer issuing registered command words; takes a new event only when idle
// depends on srarq_pkg
module srarq_back #(
    parameter int SEQ_BITS = 5,
    parameter int WINDOW   = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic                      cfg_idx,
    input  logic                      cfg_hit,
    input  logic [15:0]               cfg_data,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  srarq_pkg::event_t         q_event,
    input  logic                      q_ignore,
    input  logic [SEQ_BITS-1:0]       q_seq,
    input  logic [SEQ_BITS-1:0]       q_ack,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_command,
    output logic [1:0]                m_out_kind,
    output logic [SEQ_BITS-1:0]       m_out_seq,
    output logic [SEQ_BITS-1:0]       m_out_ack,
    output logic [$clog2(WINDOW)-1:0] m_slot,
    output logic [15:0]               m_duration,
    output logic                      m_net_enable,
    output logic                      m_last
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);

    // window state
    logic [SEQ_BITS-1:0] nts_reg, nts_next;
    logic [SEQ_BITS-1:0] ae_reg, ae_next;
    logic [SEQ_BITS-1:0] fe_reg, fe_next;
    logic [SEQ_BITS-1:0] tf_reg, tf_next;
    logic [CNT_W-1:0]    out_reg, out_next;
    logic                phys_reg, phys_next;
    logic                nak_reg, nak_next;
    logic [WINDOW-1:0]   arr_reg, arr_next;
    logic [15:0]         dto_reg, ato_reg;

    // current item
    srarq_pkg::state_t   state_reg, state_next;
    srarq_pkg::event_t   ev_reg, ev_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    logic [SEQ_BITS-1:0] ack_reg, ack_next;
    logic [1:0]          skind_reg, skind_next;
    logic [SEQ_BITS-1:0] sseq_reg, sseq_next;

    // output register
    logic                valid_reg, valid_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [1:0]          kind_reg, kind_next;
    logic [SEQ_BITS-1:0] oseq_reg, oseq_next;
    logic [SEQ_BITS-1:0] oack_reg, oack_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [15:0]         dur_reg, dur_next;
    logic                en_reg, en_next;
    logic                last_reg, last_next;

    logic                can_emit;
    logic [SLOT_W-1:0]   seq_slot, fe_slot, ae_slot, ss_slot;
    logic                rx_in, ack_in, nak_in;

    function automatic logic in_win(input logic [SEQ_BITS-1:0] a,
                                    input logic [SEQ_BITS-1:0] b,
                                    input logic [SEQ_BITS-1:0] c);
        in_win = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    assign can_emit = !valid_reg || m_ready;
    assign seq_slot = seq_reg[SLOT_W-1:0];
    assign fe_slot  = fe_reg[SLOT_W-1:0];
    assign ae_slot  = ae_reg[SLOT_W-1:0];
    assign ss_slot  = sseq_reg[SLOT_W-1:0];
    assign rx_in    = in_win(fe_reg, seq_reg, tf_reg) && !arr_reg[seq_slot];
    assign ack_in   = in_win(ae_reg, ack_reg, nts_reg);
    assign nak_in   = in_win(ae_reg, ack_reg + SEQ_ONE, nts_reg);
    assign q_ready  = (state_reg == srarq_pkg::ST_IDLE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            srarq_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (q_ignore) state_next = srarq_pkg::ST_ENABLE;
                    else begin
                        unique case (q_event)
                            srarq_pkg::EV_NET: state_next = (out_reg < WIN_CNT)
                                ? srarq_pkg::ST_SEND : srarq_pkg::ST_ENABLE;
                            srarq_pkg::EV_PHYS: state_next = srarq_pkg::ST_ENABLE;
                            srarq_pkg::EV_BAD: state_next = nak_reg
                                ? srarq_pkg::ST_SEND : srarq_pkg::ST_ENABLE;
                            srarq_pkg::EV_DATA: state_next = (q_seq != fe_reg && nak_reg)
                                ? srarq_pkg::ST_SEND : srarq_pkg::ST_RX_CHECK;
                            srarq_pkg::EV_NAK: state_next = srarq_pkg::ST_ACK_LOOP;
                            srarq_pkg::EV_ACKONLY: state_next = srarq_pkg::ST_ACK_LOOP;
                            srarq_pkg::EV_DATA_TMO: state_next = srarq_pkg::ST_SEND;
                            srarq_pkg::EV_ACK_TMO: state_next = srarq_pkg::ST_SEND;
                            default: state_next = srarq_pkg::ST_ENABLE;
                        endcase
                    end
                end
            end
            srarq_pkg::ST_SEND: if (can_emit) state_next = (skind_reg == srarq_pkg::KIND_DATA)
                ? srarq_pkg::ST_START_DATA : srarq_pkg::ST_STOP_ACK;
            srarq_pkg::ST_START_DATA: if (can_emit) state_next = srarq_pkg::ST_STOP_ACK;
            srarq_pkg::ST_STOP_ACK: if (can_emit) begin
                priority case (ev_reg)
                    srarq_pkg::EV_DATA: state_next = srarq_pkg::ST_STORE;
                    srarq_pkg::EV_NAK: state_next = srarq_pkg::ST_ACK_LOOP;
                    default: state_next = srarq_pkg::ST_ENABLE;
                endcase
            end
            // start ack timer for an in-order frame, or for any data frame while no new nak may be sent
            srarq_pkg::ST_RX_CHECK: if (can_emit) state_next = srarq_pkg::ST_STORE;
            srarq_pkg::ST_STORE: begin
                if (!rx_in) state_next = srarq_pkg::ST_ACK_LOOP;
                else if (can_emit) state_next = srarq_pkg::ST_DELIVER;
            end
            srarq_pkg::ST_DELIVER: begin
                if (!arr_reg[fe_slot]) state_next = srarq_pkg::ST_ACK_LOOP;
                else if (can_emit) state_next = srarq_pkg::ST_DELIVER_ACK;
            end
            srarq_pkg::ST_DELIVER_ACK: if (can_emit) state_next = srarq_pkg::ST_DELIVER;
            srarq_pkg::ST_ACK_LOOP: begin
                if (ev_reg == srarq_pkg::EV_NAK && skind_reg != srarq_pkg::KIND_ACK) begin
                    state_next = srarq_pkg::ST_ACK_LOOP;
                    if (nak_in) state_next = srarq_pkg::ST_SEND;
                end else if (!ack_in) state_next = srarq_pkg::ST_ENABLE;
            end
            srarq_pkg::ST_ENABLE: if (can_emit) state_next = srarq_pkg::ST_IDLE;
            default: state_next = srarq_pkg::ST_IDLE;
        endcase
    end

    // datapath and command words
    always_comb begin
        nts_next   = nts_reg;
        ae_next    = ae_reg;
        fe_next    = fe_reg;
        tf_next    = tf_reg;
        out_next   = out_reg;
        phys_next  = phys_reg;
        nak_next   = nak_reg;
        arr_next   = arr_reg;
        ev_next    = ev_reg;
        seq_next   = seq_reg;
        ack_next   = ack_reg;
        skind_next = skind_reg;
        sseq_next  = sseq_reg;
        valid_next = valid_reg && !m_ready;
        cmd_next   = cmd_reg;
        kind_next  = kind_reg;
        oseq_next  = oseq_reg;
        oack_next  = oack_reg;
        slot_next  = slot_reg;
        dur_next   = dur_reg;
        en_next    = en_reg;
        last_next  = last_reg;
        if (can_emit) begin
            cmd_next  = srarq_pkg::CMD_ENABLE;
            kind_next = '0;
            oseq_next = '0;
            oack_next = '0;
            slot_next = '0;
            dur_next  = '0;
            en_next   = 1'b0;
            last_next = 1'b0;
        end
        unique case (state_reg)
            srarq_pkg::ST_IDLE: begin
                if (q_valid) begin
                    ev_next    = q_event;
                    seq_next   = q_seq;
                    ack_next   = q_ack;
                    skind_next = srarq_pkg::KIND_NAK;
                    sseq_next  = '0;
                    if (!q_ignore) begin
                        unique case (q_event)
                            srarq_pkg::EV_NET: begin
                                skind_next = srarq_pkg::KIND_DATA;
                                sseq_next  = nts_reg;
                                if (out_reg < WIN_CNT) begin
                                    out_next = out_reg + CNT_W'(1);
                                    nts_next = nts_reg + SEQ_ONE;
                                end
                            end
                            srarq_pkg::EV_PHYS: phys_next = 1'b1;
                            srarq_pkg::EV_DATA_TMO: begin
                                skind_next = srarq_pkg::KIND_DATA;
                                sseq_next  = ae_reg;
                            end
                            srarq_pkg::EV_ACK_TMO: skind_next = srarq_pkg::KIND_ACK;
                            default: skind_next = srarq_pkg::KIND_NAK;
                        endcase
                    end
                end
            end
            srarq_pkg::ST_SEND: if (can_emit) begin
                valid_next = 1'b1;
                cmd_next   = srarq_pkg::CMD_SEND;
                kind_next  = skind_reg;
                oack_next  = fe_reg - SEQ_ONE;
                phys_next  = 1'b0;
                if (skind_reg == srarq_pkg::KIND_DATA) begin
                    oseq_next = sseq_reg;
                    slot_next = ss_slot;
                end
                if (skind_reg == srarq_pkg::KIND_NAK) nak_next = 1'b0;
            end
            srarq_pkg::ST_START_DATA: if (can_emit) begin
                valid_next = 1'b1;
                cmd_next   = srarq_pkg::CMD_START_DATA;
                slot_next  = ss_slot;
                dur_next   = dto_reg;
            end
            srarq_pkg::ST_STOP_ACK: if (can_emit) begin
                valid_next = 1'b1;
                cmd_next   = srarq_pkg::CMD_STOP_ACK;
                // nak resend done: mark so the ack loop runs next
                skind_next = srarq_pkg::KIND_ACK;
            end
            srarq_pkg::ST_RX_CHECK, srarq_pkg::ST_DELIVER_ACK: if (can_emit) begin
                valid_next = 1'b1;
                cmd_next   = srarq_pkg::CMD_START_ACK;
                dur_next   = ato_reg;
            end
            srarq_pkg::ST_STORE: if (rx_in && can_emit) begin
                valid_next         = 1'b1;
                cmd_next           = srarq_pkg::CMD_STORE;
                slot_next          = seq_slot;
                arr_next[seq_slot] = 1'b1;
            end
            srarq_pkg::ST_DELIVER: if (arr_reg[fe_slot] && can_emit) begin
                valid_next        = 1'b1;
                cmd_next          = srarq_pkg::CMD_DELIVER;
                slot_next         = fe_slot;
                nak_next          = 1'b1;
                arr_next[fe_slot] = 1'b0;
                fe_next           = fe_reg + SEQ_ONE;
                tf_next           = tf_reg + SEQ_ONE;
            end
            srarq_pkg::ST_ACK_LOOP: begin
                if (ev_reg == srarq_pkg::EV_NAK && skind_reg != srarq_pkg::KIND_ACK) begin
                    // first pass decides on the resend
                    skind_next = srarq_pkg::KIND_ACK;
                    if (nak_in) begin
                        skind_next = srarq_pkg::KIND_DATA;
                        sseq_next  = ack_reg + SEQ_ONE;
                    end
                end else if (ack_in && can_emit) begin
                    valid_next = 1'b1;
                    cmd_next   = srarq_pkg::CMD_STOP_DATA;
                    slot_next  = ae_slot;
                    ae_next    = ae_reg + SEQ_ONE;
                    if (out_reg != '0) out_next = out_reg - CNT_W'(1);
                end
            end
            srarq_pkg::ST_ENABLE: if (can_emit) begin
                valid_next = 1'b1;
                cmd_next   = srarq_pkg::CMD_ENABLE;
                en_next    = (out_reg < WIN_CNT) && phys_reg;
                last_next  = 1'b1;
            end
            default: ;
        endcase
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srarq_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            nts_reg   <= '0;
            ae_reg    <= '0;
            fe_reg    <= '0;
            tf_reg    <= SEQ_BITS'(WINDOW);
            out_reg   <= '0;
            phys_reg  <= 1'b0;
            nak_reg   <= 1'b1;
            arr_reg   <= '0;
            dto_reg   <= 16'd2800;
            ato_reg   <= 16'd300;
            skind_reg <= srarq_pkg::KIND_NAK;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            nts_reg   <= nts_next;
            ae_reg    <= ae_next;
            fe_reg    <= fe_next;
            tf_reg    <= tf_next;
            out_reg   <= out_next;
            phys_reg  <= phys_next;
            nak_reg   <= nak_next;
            arr_reg   <= arr_next;
            skind_reg <= skind_next;
            if (cfg_we && cfg_hit && !cfg_idx) dto_reg <= cfg_data;
            if (cfg_we && cfg_hit && cfg_idx)  ato_reg <= cfg_data;
        end
    end

    // item and output payload
    always_ff @(posedge aclk) begin
        ev_reg   <= ev_next;
        seq_reg  <= seq_next;
        ack_reg  <= ack_next;
        sseq_reg <= sseq_next;
        cmd_reg  <= cmd_next;
        kind_reg <= kind_next;
        oseq_reg <= oseq_next;
        oack_reg <= oack_next;
        slot_reg <= slot_next;
        dur_reg  <= dur_next;
        en_reg   <= en_next;
        last_reg <= last_next;
    end

    assign m_valid      = valid_reg;
    assign m_command    = cmd_reg;
    assign m_out_kind   = kind_reg;
    assign m_out_seq    = oseq_reg;
    assign m_out_ack    = oack_reg;
    assign m_slot       = slot_reg;
    assign m_duration   = dur_reg;
    assign m_net_enable = en_reg;
    assign m_last       = last_reg;

`ifndef ASSERT_OFF
    a_out_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        out_reg <= WIN_CNT)
        else $error("outstanding above window");
    a_last_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && last_reg) |-> cmd_reg == srarq_pkg::CMD_ENABLE)
        else $error("last word is not enable status");
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> state_reg != srarq_pkg::ST_IDLE)
        else $error("accepted item not started");
`endif

endmodule

@@ src/selective_repeat_arq_controller_top.sv @@
// selective-repeat arq control engine, top level
// an accepted event word is queued, taken by the back end when idle and turned into registered
// command words that are held while the output stalls; a new event is taken only after
// the last one's enable word, passing states for the good-frame ack scan exit, nak resend check and a
// data frame's store or delivery check; reset: aresetn synchronous active low resets edges, flags and queue
// depends on srarq_pkg, srarq_front, srarq_back
module selective_repeat_arq_controller_top #(
    parameter int SEQ_BITS = 5,
    parameter int WINDOW   = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [15:0]               cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_action,
    input  logic                      s_frame_good,
    input  logic [1:0]                s_frame_kind,
    input  logic [SEQ_BITS-1:0]       s_frame_seq,
    input  logic [SEQ_BITS-1:0]       s_frame_ack,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_command,
    output logic [1:0]                m_out_kind,
    output logic [SEQ_BITS-1:0]       m_out_seq,
    output logic [SEQ_BITS-1:0]       m_out_ack,
    output logic [$clog2(WINDOW)-1:0] m_slot,
    output logic [15:0]               m_duration,
    output logic                      m_net_enable,
    output logic                      m_last
);

    logic                q_valid, q_ready, q_ignore;
    srarq_pkg::event_t   q_event;
    logic [SEQ_BITS-1:0] q_seq, q_ack;

    // event classification and queue
    srarq_front #(.SEQ_BITS(SEQ_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_action(s_action), .in_good(s_frame_good), .in_kind(s_frame_kind),
        .in_seq(s_frame_seq), .in_ack(s_frame_ack),
        .q_valid(q_valid), .q_ready(q_ready), .q_event(q_event),
        .q_ignore(q_ignore), .q_seq(q_seq), .q_ack(q_ack)
    );

    // window state and command sequencer
    srarq_back #(.SEQ_BITS(SEQ_BITS), .WINDOW(WINDOW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_hit(1'b1), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_event(q_event),
        .q_ignore(q_ignore), .q_seq(q_seq), .q_ack(q_ack),
        .m_valid(m_valid), .m_ready(m_ready), .m_command(m_command),
        .m_out_kind(m_out_kind), .m_out_seq(m_out_seq), .m_out_ack(m_out_ack),
        .m_slot(m_slot), .m_duration(m_duration), .m_net_enable(m_net_enable),
        .m_last(m_last)
    );

endmodule
